>>> sv/u8dec_pkg.sv
// u8dec_pkg: shared types and constants for the utf-8 stream decoder
// no dependencies; used by utf8_stream_decoder, u8dec_sva and the bench checker
package u8dec_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned PEND_W = 2;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CP_W-1:0]   code_point_t;
  typedef logic [PEND_W-1:0] pend_t;

  // U+FFFD, given for malformed or truncated input
  localparam code_point_t REPLACEMENT_CHAR = 21'h00FFFD;

  localparam pend_t PEND_NONE  = 2'd0;
  localparam pend_t PEND_ONE   = 2'd1;
  localparam pend_t PEND_TWO   = 2'd2;
  localparam pend_t PEND_THREE = 2'd3;

endpackage

>>> sv/utf8_stream_decoder.sv
// utf8_stream_decoder: byte-serial utf-8 to code point decoder
// output: the code point of a character is loaded into the output register when its last byte is taken
// throughput: one byte per cycle; in_ready drops only while a result waits on out_ready
// reset: synchronous, active-low rst_n clears the pending count, accumulator and out_valid
// depends on u8dec_pkg for types and constants
module utf8_stream_decoder (
  input  logic                     clk,
  input  logic                     rst_n,
  // input channel: one raw byte per beat
  input  logic                     in_valid,
  output logic                     in_ready,
  input  u8dec_pkg::byte_t         in_byte,
  // result channel: one code point per beat
  output logic                     out_valid,
  input  logic                     out_ready,
  output u8dec_pkg::code_point_t   out_code_point
);

  // decode state
  u8dec_pkg::pend_t       pend_r, pend_nxt;
  u8dec_pkg::code_point_t acc_r, acc_nxt;

  // output register
  logic                   out_valid_r, out_valid_nxt;
  u8dec_pkg::code_point_t out_cp_r, out_cp_nxt;

  // per-beat decode results
  logic                   in_fire;
  logic                   emit;
  u8dec_pkg::code_point_t emit_cp;
  u8dec_pkg::code_point_t acc_shift;
  logic                   is_cont;

  // a new byte is taken whenever the output register is free or is being drained
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // continuation bytes look like 10xxxxxx
  assign is_cont   = (in_byte[7:6] == 2'b10);
  // six more payload bits shift in; the top bits fall off the 21-bit window
  assign acc_shift = {acc_r[u8dec_pkg::CP_W-7:0], in_byte[5:0]};

  always_comb begin
    pend_nxt = pend_r;
    acc_nxt  = acc_r;
    emit     = 1'b0;
    emit_cp  = u8dec_pkg::REPLACEMENT_CHAR;
    if (in_fire) begin
      if (pend_r == u8dec_pkg::PEND_NONE) begin
        priority if (in_byte == '0) begin
          // terminator between characters: nothing to report
          emit = 1'b0;
        end else if (!in_byte[7]) begin
          // plain ascii passes through
          emit    = 1'b1;
          emit_cp = {13'd0, in_byte};
        end else if (is_cont) begin
          // stray continuation byte
          emit = 1'b1;
        end else if (in_byte[7:5] == 3'b110) begin
          pend_nxt = u8dec_pkg::PEND_ONE;
          acc_nxt  = {16'd0, in_byte[4:0]};
        end else if (in_byte[7:4] == 4'b1110) begin
          pend_nxt = u8dec_pkg::PEND_TWO;
          acc_nxt  = {17'd0, in_byte[3:0]};
        end else if (in_byte[7:3] == 5'b11110) begin
          pend_nxt = u8dec_pkg::PEND_THREE;
          acc_nxt  = {18'd0, in_byte[2:0]};
        end else begin
          // 0xf8 to 0xff never start a sequence
          emit = 1'b1;
        end
      end else if (!is_cont) begin
        // terminator or broken sequence: abandon it, the offending byte is dropped
        emit     = 1'b1;
        pend_nxt = u8dec_pkg::PEND_NONE;
        acc_nxt  = '0;
      end else if (pend_r == u8dec_pkg::PEND_ONE) begin
        // last continuation byte completes the character
        emit     = 1'b1;
        emit_cp  = acc_shift;
        pend_nxt = u8dec_pkg::PEND_NONE;
        acc_nxt  = '0;
      end else begin
        pend_nxt = pend_r - u8dec_pkg::PEND_ONE;
        acc_nxt  = acc_shift;
      end
    end
  end

  // output register: loads on a producing beat, empties when the consumer takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_cp_nxt    = out_cp_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_cp_nxt    = emit_cp;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= u8dec_pkg::PEND_NONE;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    out_cp_r <= out_cp_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_cp_r;

endmodule

>>> sv/u8dec_checker.sv
// u8dec_sva: port-level checks on utf8_stream_decoder over time
// depends on u8dec_pkg; bound to utf8_stream_decoder at the end of this file
module u8dec_sva (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input u8dec_pkg::byte_t       in_byte,
  input logic                   out_valid,
  input logic                   out_ready,
  input u8dec_pkg::code_point_t out_code_point
);

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_code_point))
    else $error("stalled result changed");

  // input is blocked exactly while a result is stalled
  a_ready_map: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) == !in_ready)
    else $error("in_ready does not follow the output register");

  // no result appears without an input beat
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_valid && in_ready) && (!out_valid || out_ready) |=> !out_valid)
    else $error("result appeared without an input beat");

  // the output register is empty after a reset cycle
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

endmodule

bind utf8_stream_decoder u8dec_sva u_u8dec_sva (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_byte        (in_byte),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_code_point (out_code_point)
);

>>> bench/u8dec_checker.sv
// u8dec_checker: watches both channels of the utf-8 decoder, predicts code points, compares
// depends on u8dec_pkg for byte, code point and pending-count types
module u8dec_checker (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  u8dec_pkg::byte_t       in_byte,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  u8dec_pkg::code_point_t out_code_point,
  output int                     fail_count,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  u8dec_pkg::pend_t       pend_cnt;
  u8dec_pkg::code_point_t accum;
  u8dec_pkg::code_point_t expected_cps[$];
  int                     mismatches = 0;

  // predicted decoder step for one accepted byte
  task automatic decode_byte(input u8dec_pkg::byte_t b);
    if (pend_cnt == u8dec_pkg::PEND_NONE) begin
      if (b == 8'h00) begin
        // terminator with nothing open
      end else if (b[7] == 1'b0) begin
        expected_cps.push_back(u8dec_pkg::code_point_t'(b));
      end else if (b[7:6] == 2'b10) begin
        expected_cps.push_back(u8dec_pkg::REPLACEMENT_CHAR);
      end else if (b[7:5] == 3'b110) begin
        pend_cnt = u8dec_pkg::PEND_ONE;
        accum    = u8dec_pkg::code_point_t'(b[4:0]);
      end else if (b[7:4] == 4'b1110) begin
        pend_cnt = u8dec_pkg::PEND_TWO;
        accum    = u8dec_pkg::code_point_t'(b[3:0]);
      end else if (b[7:3] == 5'b11110) begin
        pend_cnt = u8dec_pkg::PEND_THREE;
        accum    = u8dec_pkg::code_point_t'(b[2:0]);
      end else begin
        expected_cps.push_back(u8dec_pkg::REPLACEMENT_CHAR);
      end
    end else if (b[7:6] != 2'b10) begin
      // terminator or broken sequence: abandon, byte is dropped
      pend_cnt = u8dec_pkg::PEND_NONE;
      accum    = '0;
      expected_cps.push_back(u8dec_pkg::REPLACEMENT_CHAR);
    end else begin
      accum    = {accum[u8dec_pkg::CP_W-7:0], b[5:0]};
      pend_cnt = pend_cnt - u8dec_pkg::PEND_ONE;
      if (pend_cnt == u8dec_pkg::PEND_NONE) begin
        expected_cps.push_back(accum);
        accum = '0;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pend_cnt = u8dec_pkg::PEND_NONE;
      accum    = '0;
      expected_cps.delete();
    end else begin
      // result side first: a byte taken at this edge cannot be answered at the same edge
      if (out_valid && out_ready) begin
        if (expected_cps.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected code point, expected none, actual %h",
                   $time, out_code_point);
        end else if (out_code_point !== expected_cps[0]) begin
          mismatches++;
          $display("%0t: code point mismatch, expected %h, actual %h",
                   $time, expected_cps[0], out_code_point);
          void'(expected_cps.pop_front());
        end else begin
          void'(expected_cps.pop_front());
        end
      end
      if (in_valid && in_ready)
        decode_byte(in_byte);
    end
    fail_count  <= mismatches;
    outstanding <= expected_cps.size();
  end

endmodule

>>> bench/testbench.sv
// testbench: drives byte streams into utf8_stream_decoder and gives the verdict
// depends on u8dec_pkg, utf8_stream_decoder and u8dec_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  u8dec_pkg::byte_t       in_byte = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  u8dec_pkg::code_point_t out_code_point;

  int fail_count;
  int outstanding;

  // idle odds in percent, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // directed bytes: ascii extremes, stray continuations, illegal leads,
  // 2/3/4-byte characters, the largest 4-byte value, a broken sequence,
  // a terminator inside a sequence and a lead that breaks another lead
  u8dec_pkg::byte_t directed_bytes[] = '{
    8'h00, 8'h41, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF,
    8'hC2, 8'hA9,
    8'hE2, 8'h82, 8'hAC,
    8'hF7, 8'hBF, 8'hBF, 8'hBF,
    8'hE2, 8'h41,
    8'hF0, 8'h9F, 8'h00,
    8'hC3, 8'hC3
  };

  utf8_stream_decoder i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point)
  );

  u8dec_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_point (out_code_point),
    .fail_count     (fail_count),
    .outstanding    (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver side: random stalls on the result channel
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // one beat on the input channel, with an optional idle gap before it
  task automatic drive_byte(input u8dec_pkg::byte_t b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    // valid and payload hold until the handshake edge
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // hold the sender off until every predicted code point has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // one random character or piece of noise; returns how many bytes went out
  task automatic send_random_item(output int sent);
    int               kind;
    int               len;
    int               conts;
    u8dec_pkg::byte_t b;
    kind = $urandom_range(99);
    sent = 0;
    if (kind < 60) begin
      // well-formed character with random payload
      len = $urandom_range(1, 4);
      case (len)
        1: b = u8dec_pkg::byte_t'($urandom_range(1, 127));
        2: b = 8'hC0 | u8dec_pkg::byte_t'($urandom_range(0, 31));
        3: b = 8'hE0 | u8dec_pkg::byte_t'($urandom_range(0, 15));
        default: b = 8'hF0 | u8dec_pkg::byte_t'($urandom_range(0, 7));
      endcase
      drive_byte(b);
      sent++;
      for (int i = 1; i < len; i++) begin
        drive_byte(8'h80 | u8dec_pkg::byte_t'($urandom_range(0, 63)));
        sent++;
      end
    end else if (kind < 70) begin
      // string terminator
      drive_byte(8'h00);
      sent++;
    end else if (kind < 85) begin
      // truncated sequence closed by a non-continuation byte
      len = $urandom_range(2, 4);
      case (len)
        2: b = 8'hC0 | u8dec_pkg::byte_t'($urandom_range(0, 31));
        3: b = 8'hE0 | u8dec_pkg::byte_t'($urandom_range(0, 15));
        default: b = 8'hF0 | u8dec_pkg::byte_t'($urandom_range(0, 7));
      endcase
      drive_byte(b);
      sent++;
      conts = $urandom_range(0, len - 2);
      for (int i = 0; i < conts; i++) begin
        drive_byte(8'h80 | u8dec_pkg::byte_t'($urandom_range(0, 63)));
        sent++;
      end
      b = u8dec_pkg::byte_t'($urandom_range(0, 255));
      if (b[7:6] == 2'b10) b[6] = 1'b1;
      drive_byte(b);
      sent++;
    end else begin
      // any byte at all
      drive_byte(u8dec_pkg::byte_t'($urandom_range(0, 255)));
      sent++;
    end
  endtask

  initial begin
    int phase_bytes;
    int item_bytes;

    // reset held low at the start, then released once for good
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, sender and receiver both moderately busy
    send_idle_pct = 23;
    recv_idle_pct = 50;
    foreach (directed_bytes[i]) drive_byte(directed_bytes[i]);
    // sender pauses until all code points have drained
    drain_results();

    // three random phases: receiver idles more, then sender idles more, then neither
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 50;
        end
        1: begin
          send_idle_pct = 50;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_bytes = 0;
      while (phase_bytes < 150) begin
        send_random_item(item_bytes);
        phase_bytes += item_bytes;
      end
      drain_results();
    end

    // keep the clock running to catch any stray extra beat
    repeat (10) @(posedge clk);
    if (outstanding != 0)
      $display("%0t: %0d predicted code points never arrived", $time, outstanding);
    if (fail_count == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/u8dec_pkg.sv
sv/utf8_stream_decoder.sv
sv/u8dec_checker.sv
bench/u8dec_checker.sv
bench/testbench.sv
